// ===== hdl/tlpq_pkg.sv =====
// Package for the two-level priority queue: types, codes, sizes and ring helpers.
// No dependencies; every other file of the block except tlpq_ram imports it.
`default_nettype none

package tlpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REF_W       = 16;
    localparam int PRIO_W      = 4;
    localparam int COUNT_W     = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [PRIO_W-1:0] URGENT_LEVEL_RST = PRIO_W'(10);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [APB_ADDR_W-3:0] REG_URGENT_LEVEL = '0;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [REF_W-1:0]   t_ref;
    typedef logic [PRIO_W-1:0]  t_prio;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_ref  wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    function automatic t_addr ring_slot(input t_addr head, input t_fill fill);
        logic [FILL_W:0] sum;
        sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(fill);
        if (sum >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (FILL_W + 1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_addr ring_next(input t_addr head);
        return (head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

    function automatic t_count fill_to_count(input t_fill fill);
        logic [FILL_W+COUNT_W-1:0] wide;
        wide = (FILL_W + COUNT_W)'(fill);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tlpq_if.sv =====
// Handshake channel interfaces for request and response transactions.
// Depends on tlpq_pkg.
`default_nettype none

interface tlpq_in_if;
    import tlpq_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    t_ref  order_ref;
    t_prio client_priority;

    modport source (output valid, output mode, output order_ref, output client_priority,
                    input ready);
    modport sink   (input valid, input mode, input order_ref, input client_priority,
                    output ready);
endinterface

interface tlpq_out_if;
    import tlpq_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_ref    out_ref;
    logic    from_urgent;
    t_count  urgent_count;
    t_count  regular_count;

    modport source (output valid, output status, output out_ref, output from_urgent,
                    output urgent_count, output regular_count, input ready);
    modport sink   (input valid, input status, input out_ref, input from_urgent,
                    input urgent_count, input regular_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/tlpq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tlpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tlpq_cfg.sv =====
// APB configuration register holding the urgent priority level.
// Depends on tlpq_pkg.
`default_nettype none

module tlpq_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tlpq_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tlpq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tlpq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output tlpq_pkg::t_prio                         o_urgent_level
);
    import tlpq_pkg::*;

    t_prio r_urgent_level;
    logic  hit;

    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_URGENT_LEVEL);
    assign pready = 1'b1;
    assign prdata = hit ? APB_DATA_W'(r_urgent_level) : '0;
    assign o_urgent_level = r_urgent_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_urgent_level <= URGENT_LEVEL_RST;
        end else if (psel && penable && pwrite && hit) begin
            r_urgent_level <= pwdata[PRIO_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tlpq_ctrl.sv =====
// Queue controller: ring pointers, fill counts, sequencing and result register.
// Depends on tlpq_pkg and tlpq_if; drives the two store RAMs through t_mem_req.
`default_nettype none

module tlpq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  tlpq_pkg::t_prio       i_urgent_level,
    tlpq_in_if.sink               i_req,
    tlpq_out_if.source            o_rsp,
    output tlpq_pkg::t_mem_req    o_urg_mem,
    output tlpq_pkg::t_mem_req    o_reg_mem,
    input  tlpq_pkg::t_ref        i_urg_rdata,
    input  tlpq_pkg::t_ref        i_reg_rdata
);
    import tlpq_pkg::*;

    t_state  r_state, n_state;
    t_addr   r_urg_head, n_urg_head, r_reg_head, n_reg_head;
    t_fill   r_urg_fill, n_urg_fill, r_reg_fill, n_reg_fill;
    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;
    t_ref    r_out_ref, n_out_ref;
    logic    r_from_urgent, n_from_urgent;
    t_count  r_urgent_count, n_urgent_count;
    t_count  r_regular_count, n_regular_count;

    logic    accept;
    logic    to_urgent;
    logic    full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_urg_head  <= '0;
            r_reg_head  <= '0;
            r_urg_fill  <= '0;
            r_reg_fill  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_urg_head  <= n_urg_head;
            r_reg_head  <= n_reg_head;
            r_urg_fill  <= n_urg_fill;
            r_reg_fill  <= n_reg_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status        <= n_status;
        r_out_ref       <= n_out_ref;
        r_from_urgent   <= n_from_urgent;
        r_urgent_count  <= n_urgent_count;
        r_regular_count <= n_regular_count;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.out_ref       = r_out_ref;
    assign o_rsp.from_urgent   = r_from_urgent;
    assign o_rsp.urgent_count  = r_urgent_count;
    assign o_rsp.regular_count = r_regular_count;

    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign to_urgent   = (i_req.client_priority == i_urgent_level);
    assign full        = to_urgent ? (r_urg_fill == FILL_W'(QUEUE_DEPTH))
                                   : (r_reg_fill == FILL_W'(QUEUE_DEPTH));

    always_comb begin
        n_state         = r_state;
        n_urg_head      = r_urg_head;
        n_reg_head      = r_reg_head;
        n_urg_fill      = r_urg_fill;
        n_reg_fill      = r_reg_fill;
        n_out_valid     = r_out_valid;
        n_status        = r_status;
        n_out_ref       = r_out_ref;
        n_from_urgent   = r_from_urgent;
        n_urgent_count  = r_urgent_count;
        n_regular_count = r_regular_count;
        o_urg_mem       = '0;
        o_reg_mem       = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_ref     = '0;
                    n_from_urgent = 1'b0;
                    n_status      = STATUS_OK;
                    if (i_req.mode == MODE_ENQ) begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_status = STATUS_FULL;
                        end else if (to_urgent) begin
                            o_urg_mem.we    = 1'b1;
                            o_urg_mem.waddr = ring_slot(r_urg_head, r_urg_fill);
                            o_urg_mem.wdata = i_req.order_ref;
                            n_urg_fill      = r_urg_fill + 1'b1;
                        end else begin
                            o_reg_mem.we    = 1'b1;
                            o_reg_mem.waddr = ring_slot(r_reg_head, r_reg_fill);
                            o_reg_mem.wdata = i_req.order_ref;
                            n_reg_fill      = r_reg_fill + 1'b1;
                        end
                    end else if (r_urg_fill != '0) begin
                        o_urg_mem.re    = 1'b1;
                        o_urg_mem.raddr = r_urg_head;
                        n_urg_head      = ring_next(r_urg_head);
                        n_urg_fill      = r_urg_fill - 1'b1;
                        n_from_urgent   = 1'b1;
                        n_state         = ST_READ;
                    end else if (r_reg_fill != '0) begin
                        o_reg_mem.re    = 1'b1;
                        o_reg_mem.raddr = r_reg_head;
                        n_reg_head      = ring_next(r_reg_head);
                        n_reg_fill      = r_reg_fill - 1'b1;
                        n_state         = ST_READ;
                    end else begin
                        n_status    = STATUS_EMPTY;
                        n_out_valid = 1'b1;
                    end
                    n_urgent_count  = fill_to_count(n_urg_fill);
                    n_regular_count = fill_to_count(n_reg_fill);
                end
            end
            ST_READ: begin
                n_out_ref   = r_from_urgent ? i_urg_rdata : i_reg_rdata;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/two_level_priority_queue_unit.sv =====
// Two-level strict-priority queue of order references.
// Depends on tlpq_pkg, tlpq_if, tlpq_ram, tlpq_cfg and tlpq_ctrl.
//
// Usage:
//   i_req carries one transaction per operation: mode (enqueue or dequeue),
//   order_ref and client_priority. o_rsp returns exactly one result per
//   request: status, out_ref, from_urgent and both fill counts after it.
//   An enqueue whose client_priority matches the urgent_level register goes
//   to the urgent ring, otherwise to the regular ring; a full ring drops it.
//   A dequeue takes the urgent head first, then the regular head.
//   Enqueue and empty dequeue results are registered in the cycle after
//   acceptance; a dequeue that pops first does the registered read of the
//   store RAM (state ST_READ, no request taken), then registers its result.
//   Throughput: one enqueue per cycle while o_rsp.ready stays high.
//   A result waiting in the output register does not block the next request
//   as long as o_rsp.ready is high in the cycle the request is accepted;
//   while the receiver stalls, i_req.ready stays low.
//   Reset empties both rings and sets urgent_level to 10; store contents stay.
//   The user must write the APB register (address 0) while idle; not enforced.
`default_nettype none

module two_level_priority_queue_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    tlpq_in_if.sink                                 i_req,
    tlpq_out_if.source                              o_rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tlpq_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tlpq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tlpq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import tlpq_pkg::*;

    t_prio    urgent_level;
    t_mem_req urg_mem;
    t_mem_req reg_mem;
    t_ref     urg_rdata;
    t_ref     reg_rdata;

    tlpq_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_urgent_level (urgent_level)
    );

    tlpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_urgent_level (urgent_level),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_urg_mem      (urg_mem),
        .o_reg_mem      (reg_mem),
        .i_urg_rdata    (urg_rdata),
        .i_reg_rdata    (reg_rdata)
    );

    tlpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REF_W)
    ) u_urgent_store (
        .i_clk   (i_clk),
        .i_we    (urg_mem.we),
        .i_waddr (urg_mem.waddr),
        .i_wdata (urg_mem.wdata),
        .i_re    (urg_mem.re),
        .i_raddr (urg_mem.raddr),
        .o_rdata (urg_rdata)
    );

    tlpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REF_W)
    ) u_regular_store (
        .i_clk   (i_clk),
        .i_we    (reg_mem.we),
        .i_waddr (reg_mem.waddr),
        .i_wdata (reg_mem.wdata),
        .i_re    (reg_mem.re),
        .i_raddr (reg_mem.raddr),
        .o_rdata (reg_rdata)
    );

endmodule

`default_nettype wire
